>>> sv/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants for the WebSocket frame parser: parse phases,
// result kinds, header field codes and the result bundle.
// ----------------------------------------------------------------------------
package wsfp_pkg;

	// Parse phase of the incoming byte stream
	typedef enum logic [2:0] {
		PH_HDR0   = 3'd0,
		PH_HDR1   = 3'd1,
		PH_EXTLEN = 3'd2,
		PH_KEY    = 3'd3,
		PH_DATA   = 3'd4,
		PH_DEAD   = 3'd5
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Header length codes that select an extended length field
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// Remaining-byte counts for the extended length and mask key fields
	localparam logic [2:0] CNT_EXT16 = 3'd1;
	localparam logic [2:0] CNT_EXT64 = 3'd7;
	localparam logic [2:0] CNT_KEY   = 3'd3;

	// Configuration register width and reset value
	localparam int unsigned     MAXP_W          = 21;
	localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 21'd524288;

	// One result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       last;
	} result_t;

endpackage

>>> sv/wsfp_parser.sv
// ----------------------------------------------------------------------------
// wsfp_parser
// Frame header and payload parser. Holds the parse state and builds, in one
// pass of logic, the result caused by the byte transferred this cycle.
// ----------------------------------------------------------------------------
module wsfp_parser #(
	parameter int unsigned MAX_PAYLOAD_CAP = 1048576
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [7:0]                    data_byte,
	input  logic [wsfp_pkg::MAXP_W-1:0]   max_payload,
	output logic                          res_valid,
	output wsfp_pkg::result_t             res
);
	import wsfp_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD_CAP + 1);
	localparam logic [63:0] CAP64 = 64'(MAX_PAYLOAD_CAP);

	phase_t            phase_q, phase_d;
	logic [3:0]        opcode_q;
	logic              mask_q;
	logic [2:0]        cnt_q;
	logic [63:0]       acc_q;
	logic [31:0]       key_q;
	logic [1:0]        midx_q;
	logic [CNT_W-1:0]  rem_q;

	logic [6:0]        len7;
	logic              is_ext16, is_ext64, is_ext;
	logic [63:0]       acc_shift, len_val, limit, maxp64, start_len;
	logic [31:0]       key_shift;
	logic              len_end, len_over, key_end, mask_now;
	logic              start, start_empty;
	logic [CNT_W-1:0]  rem_dec;
	logic              data_last;
	logic [7:0]        key_byte;

	// Shared decode of the current byte
	assign len7      = data_byte[6:0];
	assign is_ext16  = (len7 == LEN_CODE_EXT16);
	assign is_ext64  = (len7 == LEN_CODE_EXT64);
	assign is_ext    = is_ext16 | is_ext64;
	assign acc_shift = {acc_q[55:0], data_byte};
	assign key_shift = {key_q[23:0], data_byte};
	assign len_val   = (phase_q == PH_HDR1) ? {57'd0, len7} : acc_shift;
	assign mask_now  = (phase_q == PH_HDR1) ? data_byte[7] : mask_q;

	// Limit in force: smaller of register and cap
	assign maxp64 = {{(64-MAXP_W){1'b0}}, max_payload};
	assign limit  = (maxp64 > CAP64) ? CAP64 : maxp64;

	// Length known, key known, payload start
	assign len_end  = take && (((phase_q == PH_HDR1) && !is_ext) ||
	                           ((phase_q == PH_EXTLEN) && (cnt_q == 3'd0)));
	assign len_over = (len_val > limit);
	assign key_end  = take && (phase_q == PH_KEY) && (cnt_q == 3'd0);
	assign start    = (len_end && !len_over && !mask_now) || key_end;
	assign start_len   = key_end ? acc_q : len_val;
	assign start_empty = (start_len == 64'd0);

	assign rem_dec   = rem_q - CNT_W'(1);
	assign data_last = (rem_dec == '0);

	// Key byte for the current payload index, first key byte first
	always_comb begin
		case (midx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			case (phase_q)
				PH_HDR0: phase_d = PH_HDR1;
				PH_HDR1, PH_EXTLEN: begin
					if (len_end) begin
						if (len_over)
							phase_d = PH_DEAD;
						else if (mask_now)
							phase_d = PH_KEY;
						else
							phase_d = start_empty ? PH_HDR0 : PH_DATA;
					end else begin
						phase_d = PH_EXTLEN;
					end
				end
				PH_KEY: begin
					if (key_end)
						phase_d = start_empty ? PH_HDR0 : PH_DATA;
				end
				PH_DATA: begin
					if (data_last)
						phase_d = PH_HDR0;
				end
				PH_DEAD: phase_d = PH_DEAD;
				default: phase_d = PH_HDR0;
			endcase
		end
	end

	// Result for the byte transferred this cycle
	always_comb begin
		res_valid  = 1'b0;
		res.kind   = KIND_DATA;
		res.data   = 8'd0;
		res.opcode = opcode_q;
		res.last   = 1'b0;
		if (len_end && len_over) begin
			res_valid = 1'b1;
			res.kind  = KIND_ERROR;
		end else if (start && start_empty) begin
			res_valid = 1'b1;
			res.kind  = KIND_EMPTY;
			res.last  = 1'b1;
		end else if (take && (phase_q == PH_DATA)) begin
			res_valid = 1'b1;
			res.data  = data_byte ^ (mask_q ? key_byte : 8'd0);
			res.last  = data_last;
		end
	end

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Header fields, counters and key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			cnt_q    <= 3'd0;
			acc_q    <= 64'd0;
			key_q    <= 32'd0;
			midx_q   <= 2'd0;
			rem_q    <= '0;
		end else if (take) begin
			case (phase_q)
				PH_HDR0: opcode_q <= data_byte[3:0];
				PH_HDR1: begin
					mask_q <= data_byte[7];
					acc_q  <= is_ext ? 64'd0 : {57'd0, len7};
					// short length: the key count is next, if masked
					cnt_q  <= is_ext16 ? CNT_EXT16 : (is_ext64 ? CNT_EXT64 : CNT_KEY);
				end
				PH_EXTLEN: begin
					acc_q <= acc_shift;
					// last length byte: the key count is next, if masked
					cnt_q <= (cnt_q == 3'd0) ? CNT_KEY : cnt_q - 3'd1;
				end
				PH_KEY: begin
					key_q <= key_shift;
					cnt_q <= cnt_q - 3'd1;
				end
				PH_DATA: begin
					midx_q <= midx_q + 2'd1;
					rem_q  <= rem_dec;
				end
				default: ;
			endcase
			// payload start: length fits the count by the limit check
			if (start) begin
				midx_q <= 2'd0;
				rem_q  <= start_len[CNT_W-1:0];
			end
		end
	end

endmodule

>>> sv/wsfp_result_reg.sv
// ----------------------------------------------------------------------------
// wsfp_result_reg
// Output register for result items. Loads a new result whenever it is empty
// or its current result transfers in the same cycle.
// ----------------------------------------------------------------------------
module wsfp_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              res_valid,
	input  wsfp_pkg::result_t res,
	input  logic              out_stall,
	output logic              ready,
	output logic              out_valid,
	output wsfp_pkg::result_t res_q
);
	import wsfp_pkg::*;

	logic valid_q;

	// Room for a new result when empty or draining
	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= take && res_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ready && take && res_valid) begin
			res_q <= res;
		end
	end

endmodule

>>> sv/websocket_frame_parser_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser_top
// WebSocket receive deframer: parses stream bytes into unmasked payload
// bytes, empty-frame marks and a length error.
//
//   channel   dir   handshake            payload
//   --------  ----  -------------------  ----------------------------------
//   input     in    in_valid / in_stall  data_byte
//   result    out   out_valid/out_stall  result_kind, payload_byte,
//                                        frame_opcode, last_byte
//   config    in    cfg_we               cfg_wdata (max_payload)
//
// One byte per cycle while in_stall is low; a result appears in the cycle after
// the byte that causes it, from a single output register.
// in_stall is high only while a result sits in the output register and
// out_stall holds it there.
// Reset clears the parse state and loads max_payload with 524288.
// After a length error no further results come until reset.
// ----------------------------------------------------------------------------
module websocket_frame_parser_top #(
	parameter int unsigned MAX_PAYLOAD_CAP = 1048576
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  result_kind,
	output logic [7:0]                  payload_byte,
	output logic [3:0]                  frame_opcode,
	output logic                        last_byte,
	input  logic                        cfg_we,
	input  logic [wsfp_pkg::MAXP_W-1:0] cfg_wdata
);
	import wsfp_pkg::*;

	logic [MAXP_W-1:0] max_payload_q;
	logic              take, ready, res_valid;
	result_t           res, res_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	// Input transfer
	assign in_stall = !ready;
	assign take     = in_valid && ready;

	wsfp_parser #(
		.MAX_PAYLOAD_CAP(MAX_PAYLOAD_CAP)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.max_payload(max_payload_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	wsfp_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.res_valid(res_valid),
		.res      (res),
		.out_stall(out_stall),
		.ready    (ready),
		.out_valid(out_valid),
		.res_q    (res_q)
	);

	assign result_kind  = res_q.kind;
	assign payload_byte = res_q.data;
	assign frame_opcode = res_q.opcode;
	assign last_byte    = res_q.last;

	// Error result carries no byte and no last mark
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_ERROR) |-> (!last_byte && payload_byte == 8'd0))
		else $error("length error result has byte or last mark");

	// Empty-frame result is always last and carries no byte
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_EMPTY) |-> (last_byte && payload_byte == 8'd0))
		else $error("empty-frame result malformed");

	// Nothing follows a transferred length error
	a_dead_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && result_kind == KIND_ERROR) |=> !out_valid)
		else $error("result after length error");

endmodule

>>> sim/wsfp_checker.sv
// ----------------------------------------------------------------------------
// wsfp_checker
// Passive checker for the WebSocket frame parser. It watches the byte input,
// the result output and the max_payload write port, runs its own frame
// parser on every byte transfer and compares each result transfer, field by
// field, with the oldest predicted result. It reports the mismatch count and
// the number of predicted results still waiting.
// ----------------------------------------------------------------------------
module wsfp_checker #(
	parameter int unsigned PAYLOAD_CAP = 1048576
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [1:0]                  result_kind,
	input  logic [7:0]                  payload_byte,
	input  logic [3:0]                  frame_opcode,
	input  logic                        last_byte,
	input  logic                        cfg_we,
	input  logic [wsfp_pkg::MAXP_W-1:0] cfg_wdata,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import wsfp_pkg::*;

	// Parser state mirrored from the block
	phase_t            phase;
	logic [3:0]        opc;
	logic              masked;
	logic [2:0]        fcnt;
	logic [63:0]       len_acc;
	logic [31:0]       key;
	logic [1:0]        kidx;
	logic [20:0]       remaining;
	logic [MAXP_W-1:0] max_len;

	// Results predicted but not yet seen on the output
	result_t due_results[$];

	// Key is complete (or absent): start the payload or close an empty frame
	task automatic open_payload(output bit emitted, output result_t r);
		emitted = 1'b0;
		r = '0;
		kidx = '0;
		if (len_acc == 64'd0) begin
			remaining = '0;
			phase = PH_HDR0;
			emitted = 1'b1;
			r = '{kind: KIND_EMPTY, data: 8'h00, opcode: opc, last: 1'b1};
		end else begin
			remaining = len_acc[20:0];
			phase = PH_DATA;
		end
	endtask

	// Length is complete: check it against the limit in force
	task automatic close_length(output bit emitted, output result_t r);
		logic [63:0] lim;
		lim = (max_len > PAYLOAD_CAP) ? 64'(PAYLOAD_CAP) : 64'(max_len);
		emitted = 1'b0;
		r = '0;
		if (len_acc > lim) begin
			phase = PH_DEAD;
			emitted = 1'b1;
			r = '{kind: KIND_ERROR, data: 8'h00, opcode: opc, last: 1'b0};
		end else if (masked) begin
			key = '0;
			fcnt = CNT_KEY;
			phase = PH_KEY;
		end else begin
			open_payload(emitted, r);
		end
	endtask

	// Advance the parser by one stream byte
	task automatic parse_byte(input logic [7:0] b, output bit emitted, output result_t r);
		logic [7:0] plain;
		emitted = 1'b0;
		r = '0;
		case (phase)
			PH_HDR0: begin
				opc = b[3:0];
				phase = PH_HDR1;
			end
			PH_HDR1: begin
				masked = b[7];
				len_acc = '0;
				if (b[6:0] == LEN_CODE_EXT16) begin
					fcnt = CNT_EXT16;
					phase = PH_EXTLEN;
				end else if (b[6:0] == LEN_CODE_EXT64) begin
					fcnt = CNT_EXT64;
					phase = PH_EXTLEN;
				end else begin
					len_acc = 64'(b[6:0]);
					close_length(emitted, r);
				end
			end
			PH_EXTLEN: begin
				len_acc = {len_acc[55:0], b};
				if (fcnt == 3'd0)
					close_length(emitted, r);
				else
					fcnt = fcnt - 3'd1;
			end
			PH_KEY: begin
				key = {key[23:0], b};
				if (fcnt == 3'd0)
					open_payload(emitted, r);
				else
					fcnt = fcnt - 3'd1;
			end
			PH_DATA: begin
				// key byte 0 is the first one received
				plain = masked ? (b ^ key[8*(3-kidx) +: 8]) : b;
				kidx = kidx + 2'd1;
				if (remaining != '0)
					remaining = remaining - 21'd1;
				if (remaining == '0)
					phase = PH_HDR0;
				emitted = 1'b1;
				r = '{kind: KIND_DATA, data: plain, opcode: opc, last: (remaining == '0)};
			end
			default: ; // dead after a length error
		endcase
	endtask

	// Sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		result_t made;
		bit      emitted;
		if (!arst_n) begin
			phase = PH_HDR0;
			opc = '0;
			masked = 1'b0;
			fcnt = '0;
			len_acc = '0;
			key = '0;
			kidx = '0;
			remaining = '0;
			max_len = MAX_PAYLOAD_RST;
			due_results.delete();
			pending = 0;
		end else begin
			// result transfer: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				seen = '{kind: result_kind, data: payload_byte, opcode: frame_opcode,
					last: last_byte};
				if (due_results.size() == 0) begin
					$error("unexpected result: kind %0d byte %h opcode %h last %0d",
						seen.kind, seen.data, seen.opcode, seen.last);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (seen.kind !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, seen.kind);
						fail_count++;
					end
					if (seen.data !== want.data) begin
						$error("payload_byte: expected %h, got %h", want.data, seen.data);
						fail_count++;
					end
					if (seen.opcode !== want.opcode) begin
						$error("frame_opcode: expected %h, got %h", want.opcode, seen.opcode);
						fail_count++;
					end
					if (seen.last !== want.last) begin
						$error("last_byte: expected %0d, got %0d", want.last, seen.last);
						fail_count++;
					end
				end
			end
			// byte transfer: predict
			if (in_valid && !in_stall) begin
				parse_byte(data_byte, emitted, made);
				if (emitted)
					due_results.push_back(made);
			end
			if (cfg_we)
				max_len = cfg_wdata;
			pending = due_results.size();
		end
	end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the WebSocket frame parser. Sends a few hand-picked frames,
// then random well-formed frames under a sweep of max_payload settings, with
// random idle bursts on both sides, a long output hold-off and a final
// oversized frame followed by bytes that must be dropped. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wsfp_pkg::*;

	localparam int unsigned PAYLOAD_CAP = 1048576;
	localparam int          HOLD_CYCLES = 120;

	// Opcodes used by the hand-picked frames
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_RSV_F  = 4'hF;

	// How the payload length is carried in the header
	typedef enum int {
		ENC_SHORT,
		ENC_EXT16,
		ENC_EXT64
	} len_enc_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        data_byte;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        result_kind;
	logic [7:0]        payload_byte;
	logic [3:0]        frame_opcode;
	logic              last_byte;
	logic              cfg_we;
	logic [MAXP_W-1:0] cfg_wdata;

	int          fail_count;
	int          pending;
	int          idle_pct;
	int          stall_pct;
	bit          hold_req;
	bit          quiet;
	int unsigned sent_bytes;
	int unsigned len_limit;

	websocket_frame_parser_top #(
		.MAX_PAYLOAD_CAP(PAYLOAD_CAP)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.payload_byte(payload_byte),
		.frame_opcode(frame_opcode),
		.last_byte   (last_byte),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	wsfp_checker #(
		.PAYLOAD_CAP(PAYLOAD_CAP)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.payload_byte(payload_byte),
		.frame_opcode(frame_opcode),
		.last_byte   (last_byte),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 15;
			default: return 35;
		endcase
	endfunction

	// One byte transfer, with an optional idle burst ahead of it
	task automatic send_byte(input logic [7:0] b);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		sent_bytes++;
	endtask

	// Header, optional key and payload of one frame
	task automatic send_frame(input logic [7:0] first, input logic [63:0] len,
			input len_enc_t enc, input bit masked, input logic [31:0] key, input bit body);
		send_byte(first);
		case (enc)
			ENC_SHORT: send_byte({masked, len[6:0]});
			ENC_EXT16: begin
				send_byte({masked, LEN_CODE_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte({masked, LEN_CODE_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8*i +: 8]);
			end
		endcase
		if (!body)
			return;
		if (masked)
			for (int i = 3; i >= 0; i--)
				send_byte(key[8*i +: 8]);
		for (longint unsigned j = 0; j < len; j++)
			send_byte(8'($urandom));
	endtask

	// Random well-formed frame within the current limit, mostly short
	task automatic random_frame();
		int unsigned sel;
		int unsigned span;
		int unsigned len;
		len_enc_t    enc;
		sel = $urandom_range(0, 99);
		span = (sel < 60) ? 20 : ((sel < 88) ? 125 : 600);
		if (span > len_limit)
			span = len_limit;
		len = $urandom_range(0, span);
		sel = $urandom_range(0, 99);
		if (len < 126 && sel < 70)
			enc = ENC_SHORT;
		else if (sel < 85)
			enc = ENC_EXT16;
		else
			enc = ENC_EXT64;
		send_frame(8'($urandom), 64'(len), enc, 1'($urandom), $urandom, 1'b1);
	endtask

	task automatic run_random(input int unsigned n_bytes);
		int unsigned stop_at;
		int          frames;
		stop_at = sent_bytes + n_bytes;
		frames = 0;
		while (sent_bytes < stop_at) begin
			if (!quiet && frames % 6 == 0) begin
				idle_pct = pick_pct();
				stall_pct = pick_pct();
			end
			random_frame();
			frames++;
		end
	endtask

	// Stop sending and wait for every predicted result, then a short settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// max_payload write, only with the block idle
	task automatic write_max(input logic [MAXP_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		len_limit = (v > PAYLOAD_CAP) ? PAYLOAD_CAP : v;
	endtask

	// Main sequence
	initial begin
		int unsigned v;
		logic [63:0] bad_len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		quiet = 1'b0;
		sent_bytes = 0;
		len_limit = MAX_PAYLOAD_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// hand-picked frames under the reset limit
		send_frame({4'h8, OP_TEXT}, 64'd1, ENC_SHORT, 1'b0, 32'h0, 1'b1);
		// masked empty frame: result comes with the last key byte
		send_frame({4'hF, OP_RSV_F}, 64'd0, ENC_SHORT, 1'b1, 32'hFFFF_FFFF, 1'b1);
		send_frame({4'h0, OP_CONT}, 64'd0, ENC_SHORT, 1'b0, 32'h0, 1'b1);
		send_frame({4'h8, OP_BINARY}, 64'd2, ENC_SHORT, 1'b1, 32'hA500_FF3C, 1'b1);
		send_frame({4'h8, OP_PING}, 64'd1, ENC_EXT16, 1'b0, 32'h0, 1'b1);

		// zero limit: only empty frames pass
		write_max('0);
		for (int e = 0; e < 3; e++)
			for (int m = 0; m < 2; m++)
				send_frame(8'($urandom), 64'd0, len_enc_t'(e), m[0], $urandom, 1'b1);

		write_max(21'd1);
		run_random(60);

		// register above the cap acts as the cap
		write_max('1);
		// long output hold-off while a long frame keeps coming
		idle_pct = 0;
		hold_req = 1'b1;
		send_frame(8'($urandom), 64'd100, ENC_SHORT, 1'b1, $urandom, 1'b1);
		run_random(500);

		write_max(MAXP_W'(PAYLOAD_CAP));
		run_random(400);

		// frames right at a small limit
		v = $urandom_range(2, 300);
		write_max(MAXP_W'(v));
		send_frame(8'($urandom), 64'(v), (v < 126) ? ENC_SHORT : ENC_EXT16, 1'b1,
			$urandom, 1'b1);
		send_frame(8'($urandom), 64'(v - 1), ENC_EXT64, 1'b0, 32'h0, 1'b1);
		run_random(350);

		// last part of the run without idling
		quiet = 1'b1;
		idle_pct = 0;
		stall_pct = 0;
		run_random(200);

		// oversized frame, then bytes that must all be dropped
		case ($urandom_range(0, 3))
			0: begin
				write_max('1);
				bad_len = {1'b1, 31'($urandom), 32'($urandom)};
				send_frame(8'($urandom), bad_len, ENC_EXT64, 1'($urandom), 32'h0, 1'b0);
			end
			1: begin
				write_max('1);
				bad_len = 64'(PAYLOAD_CAP) + 64'd1;
				send_frame(8'($urandom), bad_len, ENC_EXT64, 1'($urandom), 32'h0, 1'b0);
			end
			2: begin
				v = $urandom_range(0, 124);
				write_max(MAXP_W'(v));
				send_frame(8'($urandom), 64'(v + 1), ENC_SHORT, 1'($urandom), 32'h0, 1'b0);
			end
			default: begin
				v = $urandom_range(126, 3000);
				write_max(MAXP_W'(v));
				send_frame(8'($urandom), 64'(v + 1), ENC_EXT16, 1'($urandom), 32'h0, 1'b0);
			end
		endcase
		repeat (40) send_byte(8'($urandom));
		in_valid <= 1'b0;

		// wait for the tail, bounded
		for (int i = 0; i < 2000 && pending != 0; i++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
sv/wsfp_pkg.sv
sv/wsfp_parser.sv
sv/wsfp_result_reg.sv
sv/websocket_frame_parser_top.sv
sim/wsfp_checker.sv
sim/tb_top.sv
